[src/mrcs_pkg.sv]
// Shared types and constants for the Modbus RTU coil slave.
`default_nettype none
package mrcs_pkg;
  localparam logic [1:0] FUNC_RX_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_COIL_WR   = 2'd1;
  localparam logic [1:0] FUNC_COIL_RD   = 2'd2;
  localparam logic [1:0] FUNC_NONE      = 2'd3;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] MAX_COUNT     = 16'd2000;
  localparam logic [7:0]  BROADCAST_ID  = 8'h00;
  localparam logic [7:0]  FC_READ_COILS = 8'd1;
  // function codes that are accepted but not implemented (no reply, no error)
  localparam logic [7:0]  FC_READ_HOLD   = 8'd3;
  localparam logic [7:0]  FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0]  FC_WRITE_REG   = 8'd6;
  localparam logic [7:0]  FC_WRITE_COILS = 8'd15;
  localparam logic [7:0]  FC_WRITE_REGS  = 8'd16;
  localparam logic [7:0]  DEVICE_ID_RST = 8'd1;
  localparam int          REG_DEVICE_ID = 0;

  // one bit of the reflected CRC-16
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction
endpackage
`default_nettype wire

[src/modbus_rtu_coil_slave_top.sv]
// Top level of the Modbus RTU read-coils slave.
// Line bytes and local writes are taken in S_IDLE; a local read is answered from S_RDWAIT.
// Frame end: a short frame is rejected in S_CRCRD; a longer frame is checked byte by byte
//   by the serial CRC unit, then range checked in S_CHECK; reply bytes follow, each held
//   while the CRC unit is busy. out_valid strobes; receiver cannot stall.
// Reset: synchronous; counters, frame length, device_id reset; coil store cleared by a sweep
//   over all NUM_BANKS*COILS_PER_BANK coils with busy held high.
`default_nettype none
module modbus_rtu_coil_slave_top #(
  parameter int NUM_BANKS      = 4,
  parameter int COILS_PER_BANK = 256,
  parameter int FRAME_BYTES    = 256,
  parameter int OFFSET_BITS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_end,
  input  wire logic [3:0]  bank,
  input  wire logic [9:0]  coil_address,
  input  wire logic        coil_value,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             coil_state,
  output logic [15:0]      error_count,
  output logic [15:0]      response_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mrcs_pkg::*;

  localparam int COIL_TOTAL = NUM_BANKS * COILS_PER_BANK;
  localparam int CAW = $clog2(COIL_TOTAL);
  localparam int FAW = $clog2(FRAME_BYTES);

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001, S_IDLE = 15'h0002, S_RDWAIT = 15'h0004,
    S_CRCRD = 15'h0010, S_CRCLD = 15'h0020,
    S_CRCRUN = 15'h0040, S_TAIL = 15'h0080, S_DECODE = 15'h0100,
    S_CHECK = 15'h0200, S_COILRD = 15'h0400, S_COILW = 15'h0800,
    S_EMIT = 15'h1000, S_EMITW = 15'h2000, S_FIELD = 15'h4000
  } state_t;
  state_t state;

  // config
  logic [7:0] device_id;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) device_id <= DEVICE_ID_RST;
    else if (psel && penable && pwrite && paddr == 2'(REG_DEVICE_ID))
      device_id <= pwdata[7:0];
  end
  assign prdata = (paddr == 2'(REG_DEVICE_ID)) ? {24'h0, device_id} : 32'h0;

  // memories
  logic           f_we, c_we, c_wd, c_rd;
  logic [FAW-1:0] f_addr;
  logic [7:0]     f_wd, f_rd;
  logic [CAW-1:0] c_addr;
  mrcs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));
  mrcs_ram #(.WIDTH(1), .DEPTH(COIL_TOTAL)) u_coil (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));

  logic       crc_init, crc_load, crc_busy;
  logic [7:0] crc_data;
  logic [15:0] crc;
  mrcs_crc u_crc (.clk(clk), .rst(rst), .init(crc_init), .load(crc_load),
    .data(crc_data), .busy(crc_busy), .crc(crc));

  logic [8:0]     flen, idx;
  logic [CAW:0]   clr;
  logic [7:0]     hdr [6];   // first six frame bytes, captured during the CRC pass
  logic [7:0]     lo2, lo1;  // last two bytes
  logic [15:0]    count, coil_i;
  logic [15:0]    cstart;
  logic [7:0]     shreg, nbytes;
  logic [2:0]     bitn;
  logic [1:0]     phase;     // 0 header, 1 data, 2 crc hi, 3 crc lo
  logic [8:0]     emit_i;
  logic           loc_ok;
  logic [CAW-1:0] loc_addr, cbase;
  logic           loc_ok_q;  // range check of the pending local read
  logic           crc_load_q;

  assign loc_ok = (32'(bank) < NUM_BANKS) && (32'(coil_address) < COILS_PER_BANK);
  assign loc_addr = CAW'(32'(bank) * COILS_PER_BANK + 32'(coil_address));
  assign busy = state != S_IDLE;

  logic [15:0] raw;
  logic [15:0] rbank;
  assign raw   = {hdr[2], hdr[3]};
  assign rbank = raw >> OFFSET_BITS;

  always_comb begin
    f_we = 1'b0; f_wd = rx_byte; f_addr = FAW'(idx);
    c_we = 1'b0; c_wd = coil_value; c_addr = loc_addr;
    crc_init = 1'b0; crc_load = 1'b0; crc_data = f_rd;
    case (state)
      S_CLEAR: begin c_we = 1'b1; c_wd = 1'b0; c_addr = CAW'(clr); end
      S_IDLE: begin
        f_addr = FAW'(flen);
        f_we = start && func == FUNC_RX_BYTE && 32'(flen) < FRAME_BYTES;
        c_we = start && func == FUNC_COIL_WR && loc_ok;
      end
      S_CRCLD: crc_load = idx < flen - 9'd2 + 9'd1 && idx != 9'd0 ? 1'b1 : 1'b0;
      // idx is already one ahead here; keep fetching the byte that CRCLD consumes
      S_CRCRUN: f_addr = FAW'(idx - 9'd1);
      S_COILRD, S_COILW: c_addr = cbase + CAW'(coil_i);
      default: ;
    endcase
    if (state == S_CRCLD) crc_data = f_rd;
    if (state == S_CRCRD || state == S_DECODE) crc_init = 1'b1;
    if (state == S_EMIT && !crc_busy && (phase == 2'd0 || phase == 2'd1)) begin
      crc_load = 1'b1; crc_data = shreg;
    end
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (rst) begin
      state <= S_CLEAR; clr <= '0; flen <= '0;
      error_count <= '0; response_count <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + (CAW+1)'(1);
          if (32'(clr) == COIL_TOTAL - 1) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          case (func)
            FUNC_RX_BYTE: begin
              if (32'(flen) < FRAME_BYTES) flen <= flen + 9'd1;
              if (frame_end) begin
                state <= S_CRCRD; idx <= '0;
              end
            end
            FUNC_COIL_RD: state <= S_RDWAIT;
            default: ;
          endcase
          loc_ok_q <= loc_ok;
        end
        // c_rd holds the coil addressed at acceptance
        S_RDWAIT: begin
          out_valid <= 1'b1; out_byte <= 8'h00; out_last <= 1'b1;
          coil_state <= loc_ok_q & c_rd;
          state <= S_IDLE;
        end
        S_CRCRD: begin
          if (flen < 9'd4) begin
            error_count <= error_count + 16'd1; flen <= '0; state <= S_IDLE;
          end else begin
            state <= S_CRCLD; idx <= idx + 9'd1;
          end
        end
        S_CRCLD: begin
          // f_rd holds byte idx-1
          if (idx <= 9'd6) hdr[3'(idx - 9'd1)] <= f_rd;
          lo2 <= lo1; lo1 <= f_rd;
          if (idx == flen) state <= S_TAIL;
          else begin
            idx <= idx + 9'd1;
            state <= (idx < flen - 9'd2 + 9'd1) ? S_CRCRUN : S_CRCLD;
          end
        end
        S_CRCRUN: if (!crc_busy && !crc_load_q) state <= S_CRCLD;
        S_TAIL: if (!crc_busy) state <= S_FIELD;
        S_FIELD: begin
          flen <= '0;
          state <= S_IDLE;
          if (crc != {lo2, lo1}) error_count <= error_count + 16'd1;
          else if (hdr[0] != device_id && hdr[0] != BROADCAST_ID) ;
          else if (hdr[1] inside {FC_READ_HOLD, FC_WRITE_COIL, FC_WRITE_REG,
                                  FC_WRITE_COILS, FC_WRITE_REGS}) ;
          else if (hdr[1] != FC_READ_COILS || flen < 9'd6)
            error_count <= error_count + 16'd1;
          else begin
            count <= {hdr[4], hdr[5]};
            cstart <= raw & 16'((1 << OFFSET_BITS) - 1);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= S_IDLE;
          if (count == 16'd0 || count > MAX_COUNT) error_count <= error_count + 16'd1;
          else if (32'(rbank) >= NUM_BANKS ||
                   32'(cstart) + 32'(count) > COILS_PER_BANK)
            error_count <= error_count + 16'd1;
          else if (hdr[0] == BROADCAST_ID) ;
          else if (32'(3 + 2) + 32'((count + 16'd7) >> 3) > FRAME_BYTES)
            error_count <= error_count + 16'd1;
          else begin
            nbytes <= 8'((count + 16'd7) >> 3);
            cbase <= CAW'(32'(rbank) * COILS_PER_BANK + 32'(cstart));
            response_count <= response_count + 16'd1;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          phase <= 2'd0; emit_i <= '0; shreg <= device_id; coil_i <= '0;
          state <= S_EMIT;
        end
        S_EMIT: if (!crc_busy) begin
          // emit current byte
          out_valid <= 1'b1; out_byte <= shreg; coil_state <= 1'b0;
          out_last <= phase == 2'd3;
          emit_i <= emit_i + 9'd1;
          case (phase)
            2'd0: begin
              if (emit_i == 9'd0) shreg <= FC_READ_COILS;
              else if (emit_i == 9'd1) shreg <= nbytes;
              if (emit_i == 9'd2) begin
                phase <= 2'd1; shreg <= 8'h00; bitn <= '0; state <= S_COILRD;
              end
            end
            2'd1: begin
              if (coil_i == count) begin phase <= 2'd2; state <= S_EMITW; end
              else begin shreg <= 8'h00; bitn <= '0; state <= S_COILRD; end
            end
            2'd2: begin shreg <= crc[7:0]; phase <= 2'd3; end
            default: state <= S_IDLE;
          endcase
        end
        S_COILRD: state <= S_COILW;
        S_COILW: begin
          // c_rd is coil coil_i; pack LSB first
          shreg[bitn] <= c_rd;
          coil_i <= coil_i + 16'd1; bitn <= bitn + 3'd1;
          if (bitn == 3'd7 || coil_i + 16'd1 == count) state <= S_EMIT;
          else state <= S_COILRD;
        end
        S_EMITW: if (!crc_busy) begin shreg <= crc[15:8]; state <= S_EMIT; end
        default: state <= S_IDLE;
      endcase
    end
  end

  // load strobe registered, so CRCRUN never leaves before the unit starts
  always_ff @(posedge clk) begin
    crc_load_q <= crc_load;
  end
endmodule
`default_nettype wire

[src/mrcs_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module mrcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[src/mrcs_crc.sv]
// Bit-serial CRC-16 unit: a loaded byte is shifted in bit by bit while busy is high.
`default_nettype none
module mrcs_crc (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        init,
  input  wire logic        load,
  input  wire logic [7:0]  data,
  output logic             busy,
  output logic [15:0]      crc
);
  import mrcs_pkg::*;
  logic [3:0] cnt;
  assign busy = cnt != 4'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
      crc <= CRC_INIT;
    end else if (init) begin
      crc <= CRC_INIT;
      cnt <= 4'd0;
    end else if (load) begin
      crc <= crc ^ {8'h00, data};
      cnt <= 4'd8;
    end else if (busy) begin
      crc <= crc_bit(crc);
      cnt <= cnt - 4'd1;
    end
  end
endmodule
`default_nettype wire

[src/mrcs_checker.sv]
// Port-level checker for the coil slave, bound to the top level.
`default_nettype none
module mrcs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  func,
  input wire logic        out_valid,
  input wire logic        out_last,
  input wire logic [7:0]  out_byte,
  input wire logic        coil_state,
  input wire logic [15:0] error_count,
  input wire logic [15:0] response_count
);
  import mrcs_pkg::*;
  a_cnt_rst: assert property (@(posedge clk) rst |=> error_count == 16'd0 &&
    response_count == 16'd0) else $error("counters not cleared");
  a_quiet_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result during reset");
  a_err_step: assert property (@(posedge clk) disable iff (rst)
    error_count == $past(error_count) || error_count == $past(error_count) + 16'd1)
    else $error("error count jumped");
  a_coil_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && coil_state |-> out_byte == 8'h00 && out_last)
    else $error("coil read reply malformed");
  // a local read raises busy, then strobes its single reply
  a_rd_reply: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == FUNC_COIL_RD |=> busy ##1 (out_valid && out_last))
    else $error("coil read reply missing");
endmodule
bind modbus_rtu_coil_slave_top mrcs_checker u_chk (.clk(clk), .rst(rst), .start(start),
  .busy(busy), .func(func), .out_valid(out_valid), .out_last(out_last),
  .out_byte(out_byte), .coil_state(coil_state), .error_count(error_count),
  .response_count(response_count));
`default_nettype wire

[dv/modbus_rtu_coil_slave_top_test.sv]
// Self-checking testbench for the Modbus RTU read-coils slave: frames, local coil access.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_coil_slave_top_test;
  import mrcs_pkg::*;

  localparam int NB = 4;
  localparam int CPB = 256;
  localparam int FB = 256;
  localparam int OB = 8;
  localparam int WATCHDOG = 200000;

  // One pending input transaction
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic       frame_end;
    logic [3:0] bank;
    logic [9:0] coil_address;
    logic       coil_value;
  } slave_item_t;

  // One expected output transaction
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic        coil_state;
    logic [15:0] error_count;
    logic [15:0] response_count;
  } slave_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = '0;
  logic [7:0] rx_byte = '0;
  logic frame_end = 1'b0;
  logic [3:0] bank = '0;
  logic [9:0] coil_address = '0;
  logic coil_value = 1'b0;
  logic out_valid;
  logic [7:0] out_byte;
  logic out_last;
  logic coil_state;
  logic [15:0] error_count;
  logic [15:0] response_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  modbus_rtu_coil_slave_top #(
    .NUM_BANKS(NB), .COILS_PER_BANK(CPB), .FRAME_BYTES(FB), .OFFSET_BITS(OB)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .rx_byte(rx_byte),
    .frame_end(frame_end), .bank(bank), .coil_address(coil_address),
    .coil_value(coil_value), .out_valid(out_valid), .out_byte(out_byte),
    .out_last(out_last), .coil_state(coil_state), .error_count(error_count),
    .response_count(response_count), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, mirrors the slave
  logic [7:0]  exp_dev_id = DEVICE_ID_RST;
  logic [7:0]  rx_frame [FB];
  int          rx_len = 0;
  logic        coils [NB*CPB];
  logic [15:0] err_cnt = '0;
  logic [15:0] resp_cnt = '0;

  slave_item_t pending_q[$];
  slave_resp_t expected_q[$];

  int  n_items = 0, n_results = 0, n_replies = 0, n_reads = 0, mismatches = 0;
  int  idle_cycles = 0;
  bit  idle_on = 1'b1;   // random gaps on the input side
  bit  stim_done = 1'b0;

  function automatic logic [15:0] crc_add(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic slave_resp_t mk_resp(logic [7:0] b, logic l, logic c);
    slave_resp_t r;
    r.out_byte = b;
    r.out_last = l;
    r.coil_state = c;
    r.error_count = err_cnt;
    r.response_count = resp_cnt;
    return r;
  endfunction

  // Decode a completed frame, queueing any reply bytes
  task automatic decode_frame();
    int len, nbytes, total, cbank, cstart, count;
    logic [15:0] crc;
    logic [7:0] id, fc;
    logic [15:0] raw;
    logic [7:0] reply [FB];
    len = rx_len;
    rx_len = 0;
    crc = CRC_INIT;
    if (len < 4) begin
      err_cnt++;
      return;
    end
    for (int i = 0; i < len - 2; i++) crc = crc_add(crc, rx_frame[i]);
    if (crc != {rx_frame[len-2], rx_frame[len-1]}) begin
      err_cnt++;
      return;
    end
    id = rx_frame[0];
    if (id != exp_dev_id && id != BROADCAST_ID) return;
    fc = rx_frame[1];
    if (fc inside {FC_READ_HOLD, FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS})
      return;
    if (fc != FC_READ_COILS || len < 6) begin
      err_cnt++;
      return;
    end
    raw = {rx_frame[2], rx_frame[3]};
    cbank = raw >> OB;
    cstart = raw & ((1 << OB) - 1);
    count = {rx_frame[4], rx_frame[5]};
    if (count == 0 || count > MAX_COUNT) begin
      err_cnt++;
      return;
    end
    if (cbank >= NB || cstart + count > CPB) begin
      err_cnt++;
      return;
    end
    if (id == BROADCAST_ID) return;
    nbytes = (count + 7) / 8;
    total = 5 + nbytes;
    if (total > FB) begin
      err_cnt++;
      return;
    end
    for (int i = 0; i < FB; i++) reply[i] = '0;
    reply[0] = exp_dev_id;
    reply[1] = FC_READ_COILS;
    reply[2] = nbytes[7:0];
    for (int i = 0; i < count; i++)
      if (coils[cbank*CPB + cstart + i]) reply[3 + i/8][i%8] = 1'b1;
    crc = CRC_INIT;
    for (int i = 0; i < 3 + nbytes; i++) crc = crc_add(crc, reply[i]);
    reply[3 + nbytes] = crc[15:8];
    reply[4 + nbytes] = crc[7:0];
    resp_cnt++;
    n_replies++;
    for (int k = 0; k < total; k++) expected_q.push_back(mk_resp(reply[k], k == total - 1, 1'b0));
  endtask

  task automatic predict_item(slave_item_t it);
    logic ok;
    ok = (it.bank < NB) && (it.coil_address < CPB);
    case (it.func)
      FUNC_RX_BYTE: begin
        if (rx_len < FB) begin
          rx_frame[rx_len] = it.rx_byte;
          rx_len++;
        end
        if (it.frame_end) decode_frame();
      end
      FUNC_COIL_WR: begin
        if (ok) coils[it.bank*CPB + it.coil_address] = it.coil_value;
      end
      FUNC_COIL_RD: begin
        n_reads++;
        expected_q.push_back(mk_resp(8'h00, 1'b1, ok ? coils[it.bank*CPB + it.coil_address] : 1'b0));
      end
      default: ;
    endcase
  endtask

  // Driver: start stays up back to back when items are ready and no gap is due
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_item(pending_q.pop_front());
        n_items++;
      end
      if (!(start && busy)) begin
        if (idle_cycles > 0) begin
          idle_cycles--;
          start <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          idle_cycles = $urandom_range(1, 19) - 1;
          start <= 1'b0;
        end else if (pending_q.size() > 0) begin
          start <= 1'b1;
          func <= pending_q[0].func;
          rx_byte <= pending_q[0].rx_byte;
          frame_end <= pending_q[0].frame_end;
          bank <= pending_q[0].bank;
          coil_address <= pending_q[0].coil_address;
          coil_value <= pending_q[0].coil_value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed output transaction is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid) begin
      slave_resp_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction: byte %h last %b", out_byte, out_last);
      end else begin
        e = expected_q.pop_front();
        if (e.out_byte !== out_byte || e.out_last !== out_last || e.coil_state !== coil_state ||
            e.error_count !== error_count || e.response_count !== response_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp byte %h last %b coil %b err %0d resp %0d / got %h %b %b %0d %0d",
                     e.out_byte, e.out_last, e.coil_state, e.error_count, e.response_count,
                     out_byte, out_last, coil_state, error_count, response_count);
        end
      end
    end
  end

  // Watchdog: cycles with no accepted transaction on either side
  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || rst || stim_done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("modbus_rtu_coil_slave_top_test: errors");
      $finish;
    end
  end

  function automatic slave_item_t line_byte(logic [7:0] b, logic last);
    slave_item_t it;
    it = '0;
    it.func = FUNC_RX_BYTE;
    it.rx_byte = b;
    it.frame_end = last;
    it.bank = 4'($urandom);
    it.coil_address = 10'($urandom);
    it.coil_value = 1'($urandom);
    return it;
  endfunction

  function automatic slave_item_t local_item(logic [1:0] f, logic [3:0] b, logic [9:0] a, logic v);
    slave_item_t it;
    it.func = f;
    it.rx_byte = 8'($urandom);
    it.frame_end = 1'($urandom);
    it.bank = b;
    it.coil_address = a;
    it.coil_value = v;
    return it;
  endfunction

  // Queue a frame; bad_crc flips the checksum
  task automatic send_frame(logic [7:0] body [$], bit bad_crc);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = crc_add(c, body[i]);
    if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
    foreach (body[i]) pending_q.push_back(line_byte(body[i], 1'b0));
    pending_q.push_back(line_byte(c[15:8], 1'b0));
    pending_q.push_back(line_byte(c[7:0], 1'b1));
  endtask

  task automatic read_req(logic [7:0] id, logic [15:0] raw, logic [15:0] cnt, bit bad_crc);
    logic [7:0] b [$];
    b = '{id, FC_READ_COILS, raw[15:8], raw[7:0], cnt[15:8], cnt[7:0]};
    send_frame(b, bad_crc);
  endtask

  // Register write over the config port; only called while the slave is idle
  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 2'(idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_DEVICE_ID) exp_dev_id = val[7:0];
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || start || busy || expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int r;
    logic [7:0] b [$];
    int len;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        pending_q.push_back(local_item(FUNC_COIL_WR, 4'($urandom_range(0, 4)),
                                       10'($urandom_range(0, 300)), 1'($urandom)));
      end else if (r < 40) begin
        pending_q.push_back(local_item(FUNC_COIL_RD, 4'($urandom), 10'($urandom), 1'($urandom)));
      end else if (r < 42) begin
        pending_q.push_back(local_item(FUNC_NONE, 4'($urandom), 10'($urandom), 1'($urandom)));
      end else if (r < 75) begin
        // well-formed read with small counts
        read_req(($urandom_range(0, 5) == 0) ? BROADCAST_ID : exp_dev_id,
                 {6'd0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 250))},
                 16'($urandom_range(1, 12)), 1'b0);
      end else if (r < 85) begin
        read_req(($urandom_range(0, 3) == 0) ? 8'($urandom) : exp_dev_id, 16'($urandom),
                 ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                 $urandom_range(0, 4) == 0);
      end else begin
        len = $urandom_range(0, 7);
        b = {};
        b.push_back(($urandom_range(0, 1)) ? exp_dev_id : 8'($urandom));
        for (int k = 1; k < len; k++) b.push_back(8'($urandom));
        if (len < 2) begin
          foreach (b[k]) pending_q.push_back(line_byte(b[k], 1'b0));
          pending_q.push_back(line_byte(8'($urandom), 1'b1));
        end else begin
          send_frame(b, $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  initial begin
    logic [7:0] b [$];
    for (int i = 0; i < NB*CPB; i++) coils[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: coil extremes, each function, each rejection path
    pending_q.push_back(local_item(FUNC_COIL_WR, 4'd0, 10'd0, 1'b1));
    pending_q.push_back(local_item(FUNC_COIL_WR, 4'd3, 10'd255, 1'b1));
    pending_q.push_back(local_item(FUNC_COIL_WR, 4'd15, 10'd1023, 1'b1));
    pending_q.push_back(local_item(FUNC_COIL_WR, 4'd0, 10'd256, 1'b1));
    pending_q.push_back(local_item(FUNC_COIL_RD, 4'd3, 10'd255, 1'b0));
    pending_q.push_back(local_item(FUNC_COIL_RD, 4'd15, 10'd1023, 1'b0));
    pending_q.push_back(local_item(FUNC_COIL_RD, 4'd0, 10'd0, 1'b0));
    pending_q.push_back(local_item(FUNC_NONE, 4'd0, 10'd0, 1'b1));
    read_req(exp_dev_id, 16'h0000, 16'd8, 1'b0);
    read_req(exp_dev_id, 16'h0300, 16'd256, 1'b0);
    read_req(exp_dev_id, 16'h0000, 16'd0, 1'b0);
    read_req(exp_dev_id, 16'h0000, 16'd2001, 1'b0);
    read_req(exp_dev_id, 16'h0400, 16'd1, 1'b0);
    read_req(exp_dev_id, 16'h00FF, 16'd2, 1'b0);
    read_req(exp_dev_id, 16'h0000, 16'd4, 1'b1);
    read_req(BROADCAST_ID, 16'h0000, 16'd4, 1'b0);
    read_req(8'h77, 16'h0000, 16'd4, 1'b0);
    b = '{exp_dev_id, FC_READ_HOLD, 8'h00, 8'h00}; send_frame(b, 1'b0);
    b = '{exp_dev_id, 8'd7}; send_frame(b, 1'b0);
    b = '{exp_dev_id, FC_READ_COILS, 8'h00}; send_frame(b, 1'b0);
    pending_q.push_back(line_byte(8'hFF, 1'b0));
    pending_q.push_back(line_byte(8'h00, 1'b1));
    // Frame overflow: 260 bytes, kept at the first 256
    for (int i = 0; i < 260; i++) pending_q.push_back(line_byte(8'($urandom), i == 259));
    drain();

    // Configuration phases, extremes included
    write_reg(REG_DEVICE_ID, 32'd255);
    read_req(8'd255, 16'h0100, 16'd16, 1'b0);
    random_phase(6);
    drain();
    write_reg(REG_DEVICE_ID, 32'd0);
    random_phase(5);
    drain();
    write_reg(REG_DEVICE_ID, 32'($urandom_range(2, 254)));
    random_phase(6);
    drain();
    write_reg(REG_DEVICE_ID, 32'd1);
    random_phase(5);
    idle_on = 1'b0;
    random_phase(4);
    drain();
    stim_done = 1'b1;

    $display("covered %0d input transactions, %0d results, %0d frame replies, %0d coil reads",
             n_items, n_results, n_replies, n_reads);
    $display("final error count %0d, response count %0d, mismatches %0d",
             err_cnt, resp_cnt, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("modbus_rtu_coil_slave_top_test: clean");
    end else begin
      $display("modbus_rtu_coil_slave_top_test: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
